>>> rtl/lrast_pkg.sv
// types and constants shared by the line rasteriser modules
`timescale 1ns / 1ps
package lrast_pkg;

  localparam int CoordW = 6;
  localparam int QDepth = 2;

  typedef logic [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } endpoints_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   in_grid;
    logic   last_pixel;
  } pixel_t;

  // one classified line, major coordinate rising
  typedef struct packed {
    logic   steep;
    logic   up;
    coord_t m0;
    coord_t m1;
    coord_t n0;
    coord_t major_span;
    coord_t minor_span;
  } line_t;

endpackage

>>> rtl/lrast_front.sv
// front end: clamps endpoints, picks the major axis and orders the endpoints
`timescale 1ns / 1ps
module lrast_front #(
  parameter int COORD_MAX = 63
) (
  input  lrast_pkg::endpoints_t endpoints,
  input  logic                  push,
  input  logic                  q_full,
  output logic                  full,
  output logic                  q_wr,
  output lrast_pkg::line_t      q_line
);
  import lrast_pkg::*;

  coord_t ax, ay, bx, by;
  coord_t span_x, span_y;
  coord_t ma, na, mb, nb;
  logic   steep;

  function automatic coord_t clamp(input coord_t c);
    coord_t r;
    r = c;
    if ({2'b00, c} > 8'(COORD_MAX)) r = CoordW'(COORD_MAX);
    return r;
  endfunction

  always_comb begin
    ax = clamp(endpoints.start_x);
    ay = clamp(endpoints.start_y);
    bx = clamp(endpoints.end_x);
    by = clamp(endpoints.end_y);
    span_x = (ax > bx) ? ax - bx : bx - ax;
    span_y = (ay > by) ? ay - by : by - ay;
    steep = span_y > span_x;
    if (steep) begin
      ma = ay; na = ax; mb = by; nb = bx;
    end else begin
      ma = ax; na = ay; mb = bx; nb = by;
    end
    q_line.steep      = steep;
    q_line.major_span = steep ? span_y : span_x;
    q_line.minor_span = steep ? span_x : span_y;
    if (ma > mb) begin
      q_line.m0 = mb;
      q_line.m1 = ma;
      q_line.n0 = nb;
      q_line.up = na > nb;
    end else begin
      q_line.m0 = ma;
      q_line.m1 = mb;
      q_line.n0 = na;
      q_line.up = nb > na;
    end
  end

  assign full = q_full;
  assign q_wr = push && !q_full;

endmodule

>>> rtl/lrast_queue.sv
// short queue of classified lines between front and back
`timescale 1ns / 1ps
module lrast_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  lrast_pkg::line_t wdata,
  input  logic             rd,
  output lrast_pkg::line_t rdata,
  output logic             full,
  output logic             valid
);
  import lrast_pkg::*;

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);

  line_t           slots [QDepth];
  logic [PtrW-1:0] wptr, rptr;
  logic [CntW-1:0] count;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == PtrW'(QDepth - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (wr) slots[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= bump(wptr);
      if (rd) rptr <= bump(rptr);
      if (wr && !rd) count <= count + 1'b1;
      else if (rd && !wr) count <= count - 1'b1;
    end
  end

  assign rdata = slots[rptr];
  assign full  = count == CntW'(QDepth);
  assign valid = count != '0;

`ifndef ASSERT_OFF
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) rd |-> count != '0)
    else $error("queue read while empty");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr |-> count != CntW'(QDepth))
    else $error("queue write while full");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CntW'(QDepth))
    else $error("queue count out of range");
`endif

endmodule

>>> rtl/lrast_back.sv
// back end: steps one line a pixel at a time into the result register
`timescale 1ns / 1ps
module lrast_back #(
  parameter int GRID = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  lrast_pkg::line_t   q_line,
  output logic               q_rd,
  input  logic               pop,
  output logic               empty,
  output lrast_pkg::pixel_t  pixel
);
  import lrast_pkg::*;

  logic         active;
  line_t        ln;
  coord_t       m, minor;
  logic [6:0]   err;
  logic [6:0]   err_sub;
  logic         ovalid;
  logic         advance;
  logic         cur_last;
  coord_t       px, py;

  assign q_rd     = !active && q_valid;
  assign advance  = active && (!ovalid || pop);
  assign cur_last = m == ln.m1;
  assign px       = ln.steep ? minor : m;
  assign py       = ln.steep ? m : minor;
  assign err_sub  = err - {1'b0, ln.minor_span};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (q_rd) active <= 1'b1;
      else if (advance && cur_last) active <= 1'b0;
      if (advance) ovalid <= 1'b1;
      else if (pop) ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      ln    <= q_line;
      m     <= q_line.m0;
      minor <= q_line.n0;
      err   <= {2'b00, q_line.major_span[CoordW-1:1]};
    end else if (advance) begin
      m <= m + 1'b1;
      if (err_sub[6]) begin
        minor <= ln.up ? minor + 1'b1 : minor - 1'b1;
        err   <= err_sub + {1'b0, ln.major_span};
      end else begin
        err <= err_sub;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel.pixel_x    <= px;
      pixel.pixel_y    <= py;
      pixel.in_grid    <= ({1'b0, px} < 7'(GRID)) && ({1'b0, py} < 7'(GRID));
      pixel.last_pixel <= cur_last;
    end
  end

  assign empty = !ovalid;

`ifndef ASSERT_OFF
  a_stop_after_last: assert property (@(posedge clk) disable iff (rst)
    advance && cur_last |=> !active)
    else $error("stepper kept running past the last pixel");
  a_major_in_range: assert property (@(posedge clk) disable iff (rst) active |-> m <= ln.m1)
    else $error("major coordinate passed the end point");
  a_err_nonneg: assert property (@(posedge clk) disable iff (rst) active |-> !err[6])
    else $error("error term negative between steps");
`endif

endmodule

>>> rtl/line_rasterizer.sv
// top level of the Bresenham line rasteriser
`timescale 1ns / 1ps
// Takes a pair of endpoints per beat and delivers the pixels of the line between them,
// ordered by rising major coordinate, one beat per pixel with in_grid and last_pixel flags.
// The front end classifies a line in the cycle it is pushed and stores it in a two-entry
// queue, so full rises only once two lines wait behind the one being drawn. The back-end
// stepper loads a line and then steps one pixel per cycle while pop stays high, stalling
// whenever the result register is held; a line of N pixels (N = major span + 1, 1 to 64)
// occupies it until its last pixel is stepped; only then is the next line loaded.
module line_rasterizer #(
  parameter int GRID      = 10,
  parameter int COORD_MAX = 63
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lrast_pkg::endpoints_t endpoints,
  input  logic                  push,
  output logic                  full,
  output lrast_pkg::pixel_t     pixel,
  output logic                  empty,
  input  logic                  pop
);
  import lrast_pkg::*;

  logic  q_wr, q_rd, q_full, q_valid;
  line_t q_wdata, q_rdata;

  lrast_front #(.COORD_MAX(COORD_MAX)) u_front (
    .endpoints (endpoints),
    .push      (push),
    .q_full    (q_full),
    .full      (full),
    .q_wr      (q_wr),
    .q_line    (q_wdata)
  );

  lrast_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .full  (q_full),
    .valid (q_valid)
  );

  lrast_back #(.GRID(GRID)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_line  (q_rdata),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .pixel   (pixel)
  );

endmodule
